// File: rtl/tccw_pkg.sv
// Shared types and constants for the text console character writer.
// Holds the screen geometry, the character classes, the escape-parse modes
// and the queue item and result layouts. No dependencies.
package tccw_pkg;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 8;

  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int IDX_W   = 11;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int DATA_W  = 48;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_ESC   = 8'h1B;
  localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LF_HEX = 8'h66;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd15;

  // Character classes decided by the front end.
  typedef enum logic [3:0] {
    KIND_NEWLINE,
    KIND_TAB,
    KIND_RETURN,
    KIND_BACKSPACE,
    KIND_ESCAPE,
    KIND_SEMI,
    KIND_CLOSE,
    KIND_HEX,
    KIND_OTHER
  } kind_e;

  // Escape-parse modes, one-hot.
  typedef enum logic [3:0] {
    MODE_TEXT  = 4'b0001,
    MODE_FIRST = 4'b0010,
    MODE_ONE   = 4'b0100,
    MODE_TWO   = 4'b1000
  } mode_e;

  typedef struct packed {
    kind_e             kind;
    logic [3:0]        hex;
    logic [CHAR_W-1:0] char_code;
  } item_t;

  // Result layout, highest bits first so cell_write lands in bit 0.
  typedef struct packed {
    logic [5:0]        pad;
    logic [ROW_W-1:0]  cursor_row_out;
    logic [COL_W-1:0]  cursor_col_out;
    logic              format_error;
    logic              scroll_request;
    logic [ATTR_W-1:0] cell_attr;
    logic [CHAR_W-1:0] cell_char;
    logic [IDX_W-1:0]  cell_index;
    logic              cell_write;
  } result_t;

endpackage

// File: rtl/text_console_char_writer_unit.sv
// Text console character writer, top level. Depends on tccw_pkg, tccw_front,
// tccw_fifo and tccw_back.
// Throughput: one character per cycle on both sides while the result stream
// is not stalled. Each character waits in the queue, then its result is held
// in the executor's output register until it leaves. Reset: cursor home, both
// attributes 15, no escape.
module text_console_char_writer_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input stream. tdata: [7:0] char_code.
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,
  // Error attribute register write channel.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tccw_pkg::ATTR_W-1:0]  cfg_data_i,
  // Result stream. tdata: [0] cell_write, [11:1] cell_index, [19:12] cell_char,
  // [27:20] cell_attr, [28] scroll_request, [29] format_error,
  // [36:30] cursor_col_out, [41:37] cursor_row_out, [47:42] zero.
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [tccw_pkg::DATA_W-1:0]  m_axis_tdata
);
  import tccw_pkg::*;

  // The front end classifies each byte independently of any state, so the
  // escape parser and cursor logic in the back end never wait on decoding.
  // After reset the queue and the output register are empty; there is no
  // clearing pass.
  item_t   front_item;
  item_t   queued_item;
  logic    queued_valid;
  logic    exec_ready;
  result_t result;

  tccw_front u_front (
    .char_code_i (s_axis_tdata),
    .item_o      (front_item)
  );

  // The two-entry queue takes items from the producer while the consumer stalls, until it is full.
  tccw_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (s_axis_tvalid),
    .push_ready_o (s_axis_tready),
    .push_item_i  (front_item),
    .pop_valid_o  (queued_valid),
    .pop_ready_i  (exec_ready),
    .pop_item_o   (queued_item)
  );

  // Writes to the error attribute are taken every cycle. The user must issue
  // them only while the block is idle; the block itself does not enforce this.
  assign cfg_ready_o = 1'b1;

  tccw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (queued_valid),
    .item_ready_o (exec_ready),
    .item_i       (queued_item),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (result)
  );

  assign m_axis_tdata = result;

endmodule

// File: rtl/tccw_front.sv
// Front end of the console writer: classifies an incoming byte.
// Depends on tccw_pkg.
module tccw_front (
  input  logic [7:0]     char_code_i,
  output tccw_pkg::item_t item_o
);
  import tccw_pkg::*;

  logic is_digit;
  logic is_lower;

  assign is_digit = (char_code_i >= CH_ZERO) && (char_code_i <= CH_NINE);
  assign is_lower = (char_code_i >= CH_LA) && (char_code_i <= CH_LF_HEX);

  always_comb begin
    item_o.char_code = char_code_i;
    item_o.hex       = '0;
    if (is_digit) begin
      item_o.hex = 4'(char_code_i - CH_ZERO);
    end else if (is_lower) begin
      item_o.hex = 4'(char_code_i - CH_LA + 8'd10);
    end
    unique case (char_code_i)
      CH_LF:    item_o.kind = KIND_NEWLINE;
      CH_TAB:   item_o.kind = KIND_TAB;
      CH_CR:    item_o.kind = KIND_RETURN;
      CH_BS:    item_o.kind = KIND_BACKSPACE;
      CH_ESC:   item_o.kind = KIND_ESCAPE;
      CH_SEMI:  item_o.kind = KIND_SEMI;
      CH_CLOSE: item_o.kind = KIND_CLOSE;
      default:  item_o.kind = (is_digit || is_lower) ? KIND_HEX : KIND_OTHER;
    endcase
  end

endmodule

// File: rtl/tccw_fifo.sv
// Two-entry queue between the classifier and the executor.
// Depends on tccw_pkg for the item type.
module tccw_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  tccw_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output tccw_pkg::item_t pop_item_o
);
  import tccw_pkg::*;

  item_t      mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_item_o   = mem_q[rptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d  = wptr_q ^ do_push;
    rptr_d  = rptr_q ^ do_pop;
    count_d = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

endmodule

// File: rtl/tccw_back.sv
// Executor of the console writer: cursor, attribute and escape parsing,
// with the result held in an output register. Depends on tccw_pkg.
module tccw_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         item_valid_i,
  output logic                         item_ready_o,
  input  tccw_pkg::item_t              item_i,
  input  logic                         cfg_valid_i,
  input  logic [tccw_pkg::ATTR_W-1:0]  cfg_data_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output tccw_pkg::result_t            res_o
);
  import tccw_pkg::*;

  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [ATTR_W-1:0] attr_q, attr_d;
  logic [ATTR_W-1:0] err_attr_q;
  mode_e             mode_q, mode_d;
  logic              out_valid_q;
  result_t           out_q, res_d;

  logic [COL_W:0]    col_n;
  logic [ROW_W:0]    row_n;
  logic [COL_W:0]    tab_col;
  logic [11:0]       index_full;
  logic              bad;
  logic              fire;

  assign item_ready_o = !out_valid_q || res_ready_i;
  assign fire         = item_valid_i && item_ready_o;
  assign res_valid_o  = out_valid_q;
  assign res_o        = out_q;

  assign tab_col    = ({1'b0, col_q} | 8'(TAB_STOP - 1)) + 8'd1;
  assign index_full = 12'({7'd0, row_q}) * 12'(COLUMNS) + 12'({5'd0, col_q});

  always_comb begin
    col_n  = {1'b0, col_q};
    row_n  = {1'b0, row_q};
    attr_d = attr_q;
    mode_d = mode_q;
    bad    = 1'b0;
    res_d  = '0;
    unique case (mode_q)
      MODE_TEXT: begin
        unique case (item_i.kind)
          KIND_NEWLINE: begin
            col_n = '0;
            row_n = row_n + 6'd1;
          end
          KIND_TAB: begin
            col_n = (tab_col > 8'(COLUMNS)) ? 8'(COLUMNS) : tab_col;
          end
          KIND_RETURN: col_n = '0;
          KIND_BACKSPACE: begin
            if (col_q != '0) begin
              col_n = col_n - 8'd1;
            end
          end
          KIND_ESCAPE: mode_d = MODE_FIRST;
          default: begin
            // Every other byte, control codes included, lands in a cell.
            res_d.cell_write = 1'b1;
            res_d.cell_index = index_full[IDX_W-1:0];
            res_d.cell_char  = item_i.char_code;
            res_d.cell_attr  = attr_q;
            col_n = col_n + 8'd1;
            if (col_n > 8'(COLUMNS - 1)) begin
              col_n = '0;
              row_n = row_n + 6'd1;
            end
          end
        endcase
        if (row_n >= 6'(ROWS)) begin
          res_d.scroll_request = 1'b1;
          row_n = row_n - 6'd1;
        end
      end
      MODE_FIRST: begin
        if (item_i.kind == KIND_HEX) begin
          attr_d = {4'd0, item_i.hex};
          mode_d = MODE_ONE;
        end else begin
          bad = 1'b1;
        end
      end
      MODE_ONE: begin
        unique case (item_i.kind)
          KIND_HEX: begin
            attr_d = {attr_q[3:0], item_i.hex};
            mode_d = MODE_TWO;
          end
          KIND_SEMI:  mode_d = MODE_FIRST;
          KIND_CLOSE: mode_d = MODE_TEXT;
          default:    bad = 1'b1;
        endcase
      end
      MODE_TWO: begin
        unique case (item_i.kind)
          KIND_SEMI:  mode_d = MODE_FIRST;
          KIND_CLOSE: mode_d = MODE_TEXT;
          default:    bad = 1'b1;
        endcase
      end
      default: mode_d = MODE_TEXT;
    endcase
    if (bad) begin
      mode_d             = MODE_TEXT;
      attr_d             = err_attr_q;
      res_d.format_error = 1'b1;
    end
    res_d.cursor_col_out = col_n[COL_W-1:0];
    res_d.cursor_row_out = row_n[ROW_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      attr_q      <= ATTR_RESET;
      err_attr_q  <= ATTR_RESET;
      mode_q      <= MODE_TEXT;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        err_attr_q <= cfg_data_i;
      end
      if (fire) begin
        col_q       <= col_n[COL_W-1:0];
        row_q       <= row_n[ROW_W-1:0];
        attr_q      <= attr_d;
        mode_q      <= mode_d;
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res_d;
    end
  end

endmodule
